@@ hdl/ssc_pkg.sv @@
// Package for the sparse-set component store: widths, codes, dense slot layout
// and the command and status words between controller and datapath.
// No dependencies.
package ssc_pkg;

    localparam int MAX_ENTITIES = 256;
    localparam int IDX_BITS     = 8;
    localparam int GEN_BITS     = 8;
    localparam int VALUE_BITS   = 64;
    localparam int CNT_BITS     = $clog2(MAX_ENTITIES + 1);
    localparam int ADDR_BITS    = $clog2(MAX_ENTITIES);
    localparam int DENSE_BITS   = IDX_BITS + GEN_BITS + VALUE_BITS;

    // stream words rounded up to whole bytes
    localparam int IN_DATA_BITS  = ((DENSE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((VALUE_BITS + CNT_BITS + 7) / 8) * 8;
    localparam int USER_BITS     = 2;

    // result status codes
    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_MISS = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [GEN_BITS-1:0]   gen;
        logic [IDX_BITS-1:0]   owner;
    } t_dense;

    typedef enum logic [1:0] {
        DW_APPEND  = 2'd0,
        DW_INPLACE = 2'd1,
        DW_MOVE    = 2'd2
    } t_dwsel;

    typedef enum logic [1:0] {
        SW_APPEND = 2'd0,
        SW_CLEAR  = 2'd1,
        SW_MOVE   = 2'd2
    } t_swsel;

    typedef struct packed {
        logic       capture;
        logic       slot_load;
        logic       rd_last;
        logic       dense_we;
        t_dwsel     dense_wsel;
        logic       sparse_we;
        t_swsel     sparse_wsel;
        logic       count_inc;
        logic       count_dec;
        logic       res_set;
        logic [1:0] res_code;
        logic       hit_load;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic slot_ok;
        logic full;
        logic gen_match;
        logic slot_is_last;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/ssc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ssc_datapath.sv @@
// Datapath of the store: request latch, sparse map and dense slot RAMs, valid
// bits, occupancy count and output register. Depends on ssc_pkg, ssc_ram.
module ssc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssc_pkg::t_cmd                 i_cmd,
    output ssc_pkg::t_stat                o_stat,
    input  logic [1:0]                    i_in_op,
    input  logic [ssc_pkg::IDX_BITS-1:0]  i_in_idx,
    input  logic [ssc_pkg::GEN_BITS-1:0]  i_in_gen,
    input  logic [ssc_pkg::VALUE_BITS-1:0] i_in_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_out_status,
    output logic [ssc_pkg::VALUE_BITS-1:0] o_out_hit,
    output logic [ssc_pkg::CNT_BITS-1:0]  o_out_count
);
    import ssc_pkg::*;

    t_op                   r_op;
    logic [IDX_BITS-1:0]   r_idx;
    logic [GEN_BITS-1:0]   r_gen;
    logic [VALUE_BITS-1:0] r_value;
    logic [CNT_BITS-1:0]   r_slot;
    logic [CNT_BITS-1:0]   r_count;
    logic [MAX_ENTITIES-1:0] r_sp_valid;
    logic                  r_sp_vld_q;
    logic [VALUE_BITS-1:0] r_hit;
    logic [1:0]            r_res;
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [VALUE_BITS-1:0] r_out_hit;
    logic [CNT_BITS-1:0]   r_out_count;

    logic [CNT_BITS-1:0]   w_sp_rdata;
    logic [CNT_BITS-1:0]   w_sp_slot;
    logic [DENSE_BITS-1:0] w_dn_raw;
    t_dense                w_dn_rdata;
    t_dense                w_req_entry;
    logic [CNT_BITS-1:0]   w_sp_m1;
    logic [CNT_BITS-1:0]   w_slot_m1;
    logic [CNT_BITS-1:0]   w_last_m1;
    logic [ADDR_BITS-1:0]  w_dn_raddr;
    logic [ADDR_BITS-1:0]  w_dn_waddr;
    t_dense                w_dn_wdata;
    logic [ADDR_BITS-1:0]  w_sp_waddr;
    logic [CNT_BITS-1:0]   w_sp_wdata;

    // a sparse entry never written reads as "no slot"
    assign w_sp_slot  = r_sp_vld_q ? w_sp_rdata : '0;
    assign w_dn_rdata = t_dense'(w_dn_raw);
    assign w_req_entry = '{value: r_value, gen: r_gen, owner: r_idx};

    assign w_sp_m1   = w_sp_slot - CNT_BITS'(1);
    assign w_slot_m1 = r_slot - CNT_BITS'(1);
    assign w_last_m1 = r_count - CNT_BITS'(1);

    assign w_dn_raddr = i_cmd.rd_last ? w_last_m1[ADDR_BITS-1:0] : w_sp_m1[ADDR_BITS-1:0];

    always_comb begin
        case (i_cmd.dense_wsel)
            DW_INPLACE: begin
                w_dn_waddr = w_sp_m1[ADDR_BITS-1:0];
                w_dn_wdata = w_req_entry;
            end
            DW_MOVE: begin
                w_dn_waddr = w_slot_m1[ADDR_BITS-1:0];
                w_dn_wdata = w_dn_rdata;
            end
            default: begin
                w_dn_waddr = r_count[ADDR_BITS-1:0];
                w_dn_wdata = w_req_entry;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.sparse_wsel)
            SW_CLEAR: begin
                w_sp_waddr = r_idx;
                w_sp_wdata = '0;
            end
            SW_MOVE: begin
                w_sp_waddr = w_dn_rdata.owner;
                w_sp_wdata = r_slot;
            end
            default: begin
                w_sp_waddr = r_idx;
                w_sp_wdata = r_count + CNT_BITS'(1);
            end
        endcase
    end

    ssc_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_ENTITIES)) u_sparse (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sparse_we),
        .i_waddr (w_sp_waddr),
        .i_wdata (w_sp_wdata),
        .i_raddr (i_in_idx),
        .o_rdata (w_sp_rdata)
    );

    ssc_ram #(.WIDTH(DENSE_BITS), .DEPTH(MAX_ENTITIES)) u_dense (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dense_we),
        .i_waddr (w_dn_waddr),
        .i_wdata (w_dn_wdata),
        .i_raddr (w_dn_raddr),
        .o_rdata (w_dn_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_valid  <= '0;
            r_sp_vld_q  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp_vld_q <= r_sp_valid[i_in_idx];
            if (i_cmd.sparse_we) begin
                r_sp_valid[w_sp_waddr] <= 1'b1;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CNT_BITS'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_in_op);
            r_idx   <= i_in_idx;
            r_gen   <= i_in_gen;
            r_value <= i_in_value;
            r_hit   <= '0;
        end else if (i_cmd.hit_load) begin
            r_hit <= w_dn_rdata.value;
        end
        if (i_cmd.slot_load) begin
            r_slot <= w_sp_slot;
        end
        if (i_cmd.res_set) begin
            r_res <= i_cmd.res_code;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res;
            r_out_hit    <= r_hit;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.op           = r_op;
    assign o_stat.slot_ok      = (w_sp_slot != '0) && (w_sp_slot <= r_count);
    assign o_stat.full         = (r_count == CNT_BITS'(MAX_ENTITIES));
    assign o_stat.gen_match    = (w_dn_rdata.gen == r_gen);
    assign o_stat.slot_is_last = (r_slot == r_count);
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_hit    = r_out_hit;
    assign o_out_count  = r_out_count;

endmodule

@@ hdl/ssc_controller.sv @@
// Request sequencer of the store: steps each request through sparse read,
// dense read and the swap-remove move. Depends on ssc_pkg.
module ssc_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ssc_pkg::t_stat i_stat,
    output ssc_pkg::t_cmd  o_cmd
);
    import ssc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SPARSE = 5'b00010,
        S_DENSE  = 5'b00100,
        S_LAST   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SPARSE;
                end
            end
            S_SPARSE: begin
                o_cmd.slot_load = 1'b1;
                o_cmd.res_set   = 1'b1;
                o_cmd.res_code  = RES_MISS;
                n_state         = S_DONE;
                case (i_stat.op)
                    OP_UPSERT: begin
                        if (i_stat.slot_ok) begin
                            // matching or stale owner: overwrite in place
                            o_cmd.dense_we   = 1'b1;
                            o_cmd.dense_wsel = DW_INPLACE;
                            o_cmd.res_code   = RES_OK;
                        end else if (i_stat.full) begin
                            o_cmd.res_code = RES_FULL;
                        end else begin
                            o_cmd.dense_we    = 1'b1;
                            o_cmd.dense_wsel  = DW_APPEND;
                            o_cmd.sparse_we   = 1'b1;
                            o_cmd.sparse_wsel = SW_APPEND;
                            o_cmd.count_inc   = 1'b1;
                            o_cmd.res_code    = RES_OK;
                        end
                    end
                    OP_LOOKUP, OP_REMOVE: begin
                        if (i_stat.slot_ok) begin
                            n_state = S_DENSE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DENSE: begin
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = RES_MISS;
                n_state        = S_DONE;
                if (i_stat.gen_match) begin
                    o_cmd.res_code = RES_OK;
                    if (i_stat.op == OP_LOOKUP) begin
                        o_cmd.hit_load = 1'b1;
                    end else begin
                        o_cmd.sparse_we   = 1'b1;
                        o_cmd.sparse_wsel = SW_CLEAR;
                        if (i_stat.slot_is_last) begin
                            o_cmd.count_dec = 1'b1;
                        end else begin
                            o_cmd.rd_last = 1'b1;
                            n_state       = S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                // last slot's contents move into the hole
                o_cmd.dense_we    = 1'b1;
                o_cmd.dense_wsel  = DW_MOVE;
                o_cmd.sparse_we   = 1'b1;
                o_cmd.sparse_wsel = SW_MOVE;
                o_cmd.count_dec   = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/sparse_set_component_store.sv @@
// Top level of the sparse-set component store: stream ports, controller and
// datapath. Depends on ssc_pkg, ssc_controller, ssc_datapath.
//
// One value per entity, addressed by an entity index and a generation. Each
// request word gives an operation (lookup, upsert, remove) and yields exactly
// one result word: status (ok, not found, store full), the stored value on a
// lookup hit (zero otherwise) and the occupied slot count after the request.
// Requests are handled one at a time through one-read one-write RAMs for the
// sparse map and the dense slots, and the sequence of RAM reads sets the
// steps of a request. After acceptance the sparse map is read; upsert,
// unknown operations and misses at the sparse map then load their result into
// the output register, while lookup and remove first read the dense slot, and
// a remove that leaves a hole then moves the last slot into it before its
// result is loaded. The next request is taken in the cycle after the result
// is loaded. The output register lets a result wait while the next request
// is accepted; a result still waiting when the next one is done holds the
// controller in its last step until the word is taken. The sparse map is
// cleared at reset through per-entry valid bits, so no clearing pass is
// needed.
module sparse_set_component_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] ent_index, [15:8] ent_generation, [79:16] value
    input  logic [ssc_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // [1:0] operation
    input  logic [ssc_pkg::USER_BITS-1:0]      i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [63:0] hit_value, [72:64] entry_count, [79:73] zero
    output logic [ssc_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [ssc_pkg::USER_BITS-1:0]      o_m_axis_tuser
);
    import ssc_pkg::*;

    localparam int GEN_LO = IDX_BITS;
    localparam int VAL_LO = IDX_BITS + GEN_BITS;
    localparam int OUT_PAD = OUT_DATA_BITS - VALUE_BITS - CNT_BITS;

    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic [1:0]            w_out_status;
    logic [VALUE_BITS-1:0] w_out_hit;
    logic [CNT_BITS-1:0]   w_out_count;

    ssc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_op      (i_s_axis_tuser[1:0]),
        .i_in_idx     (i_s_axis_tdata[IDX_BITS-1:0]),
        .i_in_gen     (i_s_axis_tdata[VAL_LO-1:GEN_LO]),
        .i_in_value   (i_s_axis_tdata[VAL_LO+VALUE_BITS-1:VAL_LO]),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_status (w_out_status),
        .o_out_hit    (w_out_hit),
        .o_out_count  (w_out_count)
    );

    assign o_m_axis_tdata = {{OUT_PAD{1'b0}}, w_out_count, w_out_hit};
    assign o_m_axis_tuser = w_out_status;

    // one request in flight: ready drops right after a word is taken
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second request accepted while one is in flight");

    // RAM writes only happen while a request is being worked on
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.dense_we || w_cmd.sparse_we) |-> !o_s_axis_tready)
        else $error("store written while idle");

    // occupancy never moves both ways at once
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.count_inc && w_cmd.count_dec))
        else $error("count incremented and decremented together");

    // a full report comes only with a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == RES_FULL))
            |-> (w_out_count == CNT_BITS'(MAX_ENTITIES)))
        else $error("store full reported below capacity");

endmodule

@@ bench/tb_top.sv @@
// Testbench for the sparse-set component store: directed table, then random
// churn, fill-to-capacity and drain phases, checked against a predictor or typed rows.
// Depends on ssc_pkg and sparse_set_component_store.
module tb_top;
    import ssc_pkg::*;

    localparam int RANDOM_WORDS  = 550;
    localparam int CHURN_WORDS   = 180;
    localparam int SETTLE_CYCLES = 16;
    localparam int TABLE_ROWS    = 24;

    localparam logic [VALUE_BITS-1:0] ONES  = '1;
    localparam logic [VALUE_BITS-1:0] PAT_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [VALUE_BITS-1:0] PAT_B = 64'hFEDC_BA98_7654_3210;
    localparam logic [VALUE_BITS-1:0] PAT_C = 64'h8000_0000_0000_0001;

    typedef struct packed {
        t_op                   op;
        logic [IDX_BITS-1:0]   idx;
        logic [GEN_BITS-1:0]   gen;
        logic [VALUE_BITS-1:0] val;
    } t_request;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] hit;
        logic [CNT_BITS-1:0]   count;
    } t_result;

    // typed = 1: the row carries its own expected result
    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  want;
    } t_step;

    localparam t_result NO_RES = '0;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_valid;
    logic                     s_ready;
    logic [IN_DATA_BITS-1:0]  s_data;
    logic [USER_BITS-1:0]     s_user;
    logic                     m_valid;
    logic                     m_ready;
    logic [OUT_DATA_BITS-1:0] m_data;
    logic [USER_BITS-1:0]     m_user;

    // predicted store contents
    logic [CNT_BITS-1:0]   map_slot   [MAX_ENTITIES];
    logic [IDX_BITS-1:0]   slot_owner [MAX_ENTITIES];
    logic [GEN_BITS-1:0]   slot_gen   [MAX_ENTITIES];
    logic [VALUE_BITS-1:0] slot_data  [MAX_ENTITIES];
    logic [CNT_BITS-1:0]   live_slots;

    t_result pending_results [$];
    t_result oldest;
    t_step   steps [TABLE_ROWS];
    int      mismatches;
    int      words_sent;
    bit      calm;

    sparse_set_component_store u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Applies one request to the predicted store and returns its result word.
    function automatic t_result store_apply(t_request q);
        t_result             r;
        logic [CNT_BITS-1:0] s;
        logic [CNT_BITS-1:0] last;
        logic [IDX_BITS-1:0] mover;
        logic                owner_ok;
        r.status = RES_MISS;
        r.hit    = '0;
        s        = map_slot[q.idx];
        // a map entry beyond the occupied slots means no slot
        if (s > live_slots) s = '0;
        owner_ok = 1'b0;
        if (s != 0) owner_ok = (slot_gen[s-1] == q.gen);
        case (q.op)
            OP_LOOKUP: begin
                if (owner_ok) begin
                    r.status = RES_OK;
                    r.hit    = slot_data[s-1];
                end
            end
            OP_UPSERT: begin
                if (s != 0) begin
                    // same or stale owner: rewrite in place
                    slot_owner[s-1] = q.idx;
                    slot_gen[s-1]   = q.gen;
                    slot_data[s-1]  = q.val;
                    r.status        = RES_OK;
                end else if (live_slots >= MAX_ENTITIES) begin
                    r.status = RES_FULL;
                end else begin
                    slot_owner[live_slots] = q.idx;
                    slot_gen[live_slots]   = q.gen;
                    slot_data[live_slots]  = q.val;
                    map_slot[q.idx]        = CNT_BITS'(live_slots + 1);
                    live_slots             = CNT_BITS'(live_slots + 1);
                    r.status               = RES_OK;
                end
            end
            OP_REMOVE: begin
                if (owner_ok) begin
                    last            = live_slots;
                    map_slot[q.idx] = '0;
                    if (s != last) begin
                        // last slot fills the hole
                        mover           = slot_owner[last-1];
                        slot_owner[s-1] = mover;
                        slot_gen[s-1]   = slot_gen[last-1];
                        slot_data[s-1]  = slot_data[last-1];
                        map_slot[mover] = s;
                    end
                    live_slots = CNT_BITS'(last - 1);
                    r.status   = RES_OK;
                end
            end
            default: ;
        endcase
        r.count = live_slots;
        return r;
    endfunction

    // Request aimed at an occupied slot, with its owner's handle.
    function automatic t_request live_request(t_op op, bit last_slot);
        t_request q;
        int       s;
        s     = last_slot ? int'(live_slots) : int'($urandom_range(1, live_slots));
        q.op  = op;
        q.idx = slot_owner[s-1];
        q.gen = slot_gen[s-1];
        q.val = {$urandom, $urandom};
        return q;
    endfunction

    function automatic logic [GEN_BITS-1:0] odd_gen();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return GEN_BITS'(1);
            2:       return '1;
            default: return GEN_BITS'($urandom);
        endcase
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_pause();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Drives one request word at the falling edge and holds it until taken.
    task automatic send_word(t_request q, bit typed, t_result want);
        int      pause;
        t_result r;
        pause = pick_pause();
        @(negedge i_clk);
        if (pause > 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {q.val, q.gen, q.idx};
        s_user  <= q.op;
        do @(posedge i_clk); while (!s_ready);
        r = store_apply(q);
        pending_results.push_back(typed ? want : r);
        words_sent++;
    endtask

    // Result side: random back-pressure on tready.
    initial begin : sink_ready
        int stall;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = pick_pause();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    // Result checker: each word taken is matched against the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result word with nothing pending");
            end else begin
                oldest = pending_results.pop_front();
                if (m_user !== oldest.status)
                    flag_mismatch($sformatf("status %0d, want %0d", m_user, oldest.status));
                if (m_data[VALUE_BITS-1:0] !== oldest.hit)
                    flag_mismatch($sformatf("hit_value %h, want %h",
                                            m_data[VALUE_BITS-1:0], oldest.hit));
                if (m_data[VALUE_BITS+CNT_BITS-1:VALUE_BITS] !== oldest.count)
                    flag_mismatch($sformatf("entry_count %0d, want %0d",
                                            m_data[VALUE_BITS+CNT_BITS-1:VALUE_BITS],
                                            oldest.count));
                if (m_data[OUT_DATA_BITS-1:VALUE_BITS+CNT_BITS] !== '0)
                    flag_mismatch("padding bits of the result word not zero");
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_request               q;
        logic [IDX_BITS-1:0]    pool [16];
        int                     k;
        int                     r;
        i_rst_n    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_user     = '0;
        mismatches = 0;
        words_sent = 0;
        calm       = 1'b0;
        live_slots = '0;
        for (k = 0; k < MAX_ENTITIES; k++) map_slot[k] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // slots after each row are noted where they move
        steps = '{
            '{'{OP_LOOKUP, 8'd0,   8'd0,   64'd0}, 1'b1, '{RES_MISS, 64'd0, 9'd0}},
            '{'{OP_REMOVE, 8'd255, 8'd255, ONES},  1'b1, '{RES_MISS, 64'd0, 9'd0}},
            '{'{OP_NONE,   8'd7,   8'd7,   PAT_A}, 1'b1, '{RES_MISS, 64'd0, 9'd0}},
            '{'{OP_UPSERT, 8'd0,   8'd0,   64'd0}, 1'b1, '{RES_OK,   64'd0, 9'd1}},
            '{'{OP_UPSERT, 8'd255, 8'd255, ONES},  1'b1, '{RES_OK,   64'd0, 9'd2}},
            '{'{OP_LOOKUP, 8'd255, 8'd255, 64'd0}, 1'b1, '{RES_OK,   ONES,  9'd2}},
            '{'{OP_LOOKUP, 8'd0,   8'd0,   64'd0}, 1'b1, '{RES_OK,   64'd0, 9'd2}},
            '{'{OP_LOOKUP, 8'd0,   8'd1,   64'd0}, 1'b1, '{RES_MISS, 64'd0, 9'd2}},
            '{'{OP_UPSERT, 8'd0,   8'd0,   PAT_A}, 1'b1, '{RES_OK,   64'd0, 9'd2}},
            '{'{OP_LOOKUP, 8'd0,   8'd0,   64'd0}, 1'b1, '{RES_OK,   PAT_A, 9'd2}},
            // stale generation takes the slot over
            '{'{OP_UPSERT, 8'd0,   8'd5,   PAT_B}, 1'b1, '{RES_OK,   64'd0, 9'd2}},
            '{'{OP_LOOKUP, 8'd0,   8'd0,   64'd0}, 1'b1, '{RES_MISS, 64'd0, 9'd2}},
            '{'{OP_LOOKUP, 8'd0,   8'd5,   ONES},  1'b1, '{RES_OK,   PAT_B, 9'd2}},
            '{'{OP_UPSERT, 8'd128, 8'h80,  PAT_C}, 1'b1, '{RES_OK,   64'd0, 9'd3}},
            '{'{OP_REMOVE, 8'd0,   8'd0,   64'd0}, 1'b1, '{RES_MISS, 64'd0, 9'd3}},
            // hole in slot 1, entity 128 moves down
            '{'{OP_REMOVE, 8'd0,   8'd5,   64'd0}, 1'b1, '{RES_OK,   64'd0, 9'd2}},
            '{'{OP_LOOKUP, 8'd128, 8'h80,  64'd0}, 1'b0, NO_RES},
            // entity 255 now holds the last slot
            '{'{OP_REMOVE, 8'd255, 8'd255, 64'd0}, 1'b1, '{RES_OK,   64'd0, 9'd1}},
            '{'{OP_LOOKUP, 8'd255, 8'd255, 64'd0}, 1'b1, '{RES_MISS, 64'd0, 9'd1}},
            '{'{OP_NONE,   8'd128, 8'h80,  PAT_B}, 1'b1, '{RES_MISS, 64'd0, 9'd1}},
            '{'{OP_LOOKUP, 8'd128, 8'h80,  64'd0}, 1'b0, NO_RES},
            '{'{OP_REMOVE, 8'd128, 8'h80,  64'd0}, 1'b1, '{RES_OK,   64'd0, 9'd0}},
            '{'{OP_LOOKUP, 8'd128, 8'h80,  64'd0}, 1'b1, '{RES_MISS, 64'd0, 9'd0}},
            '{'{OP_UPSERT, 8'hA5,  8'h5A,  PAT_B}, 1'b0, NO_RES}
        };
        for (k = 0; k < TABLE_ROWS; k++)
            send_word(steps[k].req, steps[k].typed, steps[k].want);

        // churn over a small set of entities so that hits and moves are common
        pool[0] = '0;
        pool[1] = '1;
        for (k = 2; k < 16; k++) pool[k] = IDX_BITS'($urandom);
        for (k = 0; k < CHURN_WORDS; k++) begin
            calm  = (k >= 100 && k < 150);
            r     = $urandom_range(0, 99);
            q.idx = pool[$urandom_range(0, 15)];
            q.gen = odd_gen();
            q.val = {$urandom, $urandom};
            if (r < 30)      q.op = OP_LOOKUP;
            else if (r < 65) q.op = OP_UPSERT;
            else if (r < 93) q.op = OP_REMOVE;
            else             q.op = OP_NONE;
            if (q.op != OP_NONE && live_slots != 0 && $urandom_range(0, 9) < 7) begin
                q = live_request(q.op, $urandom_range(0, 4) == 0);
                if (q.op == OP_UPSERT && $urandom_range(0, 2) == 0)
                    q.gen = GEN_BITS'(q.gen + 1 + $urandom_range(0, 254));
            end
            send_word(q, 1'b0, NO_RES);
        end
        calm = 1'b0;

        // fill every slot with fresh entities
        while (live_slots < MAX_ENTITIES) begin
            calm = (live_slots >= 100 && live_slots < 140);
            if (live_slots != 0 && $urandom_range(0, 9) == 0) begin
                q = live_request(OP_LOOKUP, 1'b0);
            end else begin
                q.op  = OP_UPSERT;
                q.gen = GEN_BITS'($urandom);
                q.val = {$urandom, $urandom};
                do q.idx = IDX_BITS'($urandom); while (map_slot[q.idx] != 0);
            end
            send_word(q, 1'b0, NO_RES);
        end
        calm = 1'b0;

        // at capacity: takeovers and hits
        for (k = 0; k < 10; k++) begin
            q = live_request((k % 3 == 0) ? OP_UPSERT : OP_LOOKUP, k == 4);
            if (q.op == OP_UPSERT) q.gen = GEN_BITS'(q.gen + 1 + $urandom_range(0, 254));
            if (k == 9) q.gen = ~q.gen;
            send_word(q, 1'b0, NO_RES);
        end

        // drain: mostly removes of live entities, some wrong generations
        while (words_sent < TABLE_ROWS + RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (live_slots == 0 || r >= 95) begin
                q.op  = OP_NONE;
                q.idx = IDX_BITS'($urandom);
                q.gen = GEN_BITS'($urandom);
                q.val = {$urandom, $urandom};
            end else if (r < 25) begin
                q = live_request(OP_LOOKUP, 1'b0);
            end else begin
                q = live_request(OP_REMOVE, $urandom_range(0, 5) == 0);
                if (r < 35) q.gen = GEN_BITS'(q.gen + 1 + $urandom_range(0, 254));
            end
            send_word(q, 1'b0, NO_RES);
        end

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
